[rtl/tpw_pkg.sv]
// tpw_pkg: shared types, register indexes, codes and constants of the
// tiered progress watchdog; no dependencies
package tpw_pkg;

   localparam int MS_PER_SEC = 1000;

   // register indexes on the configuration port
   localparam logic [2:0] CSR_TIMEOUT_SHORT  = 3'd0;
   localparam logic [2:0] CSR_TIMEOUT_LINK   = 3'd1;
   localparam logic [2:0] CSR_TIMEOUT_UPDATE = 3'd2;
   localparam logic [2:0] CSR_BACKOFF        = 3'd3;
   localparam logic [2:0] CSR_REPEAT_WINDOW  = 3'd4;
   localparam logic [2:0] CSR_BURST_WINDOW   = 3'd5;
   localparam logic [2:0] CSR_BURST_LIMIT    = 3'd6;

   // reset values
   localparam int TIMEOUT_SHORT_RST  = 60;
   localparam int TIMEOUT_LINK_RST   = 120;
   localparam int TIMEOUT_UPDATE_RST = 180;
   localparam logic [31:0] BACKOFF_RST       = 32'(10 * 1000);
   localparam logic [31:0] REPEAT_WINDOW_RST = 32'(10 * 60 * 1000);
   localparam logic [31:0] BURST_WINDOW_RST  = 32'(60 * 60 * 1000);
   localparam logic [7:0]  BURST_LIMIT_RST   = 8'd3;

   // timeouts are kept in milliseconds: 65535 s * 1000 fits 26 bits
   localparam int LIMIT_W = 26;

   // floor(x / 1000) for 32-bit x is (x * DIV_MAGIC) >> DIV_SHIFT
   localparam int DIV_SHIFT = 38;
   localparam int MAGIC_W   = 29;
   localparam logic [MAGIC_W-1:0] DIV_MAGIC = MAGIC_W'(274877907);

   // commands
   localparam logic CMD_CHECK    = 1'b0;
   localparam logic CMD_PROGRESS = 1'b1;

   // state codes
   localparam logic [2:0] ST_IDLE       = 3'd0;
   localparam logic [2:0] ST_INIT       = 3'd1;
   localparam logic [2:0] ST_ERROR      = 3'd2;
   localparam logic [2:0] ST_SLEEPING   = 3'd3;
   localparam logic [2:0] ST_CONNECTING = 3'd4;
   localparam logic [2:0] ST_REPORTING  = 3'd5;
   localparam logic [2:0] ST_UPDATE     = 3'd6;
   localparam logic [2:0] ST_NONE       = 3'd7;

   // escalation tiers
   localparam logic [1:0] TIER_NONE       = 2'd0;
   localparam logic [1:0] TIER_BACKOFF    = 2'd1;
   localparam logic [1:0] TIER_DISCONNECT = 2'd2;
   localparam logic [1:0] TIER_RESET      = 2'd3;

   typedef struct packed {
      logic [LIMIT_W-1:0] limit_short_ms;
      logic [LIMIT_W-1:0] limit_link_ms;
      logic [LIMIT_W-1:0] limit_update_ms;
      logic [31:0]        backoff_len_ms;
      logic [31:0]        repeat_window_ms;
      logic [31:0]        burst_window_ms;
      logic [7:0]         burst_trip_limit;
   } tpw_cfg_type;

   typedef struct packed {
      logic [31:0] progress_time;
      logic [31:0] backoff_until;
      logic [31:0] window_start;
      logic [7:0]  recent_trips;
      logic [31:0] previous_trip_time;
      logic [15:0] trips_counted;
      logic [15:0] resets_counted;
   } tpw_state_type;

   typedef struct packed {
      logic [1:0]  tier;
      logic        alert;
      logic [22:0] stall_seconds;
      logic [15:0] trip_total;
      logic [15:0] reset_total;
   } tpw_result_type;

endpackage

[rtl/tpw_eval.sv]
// tpw_eval: combinational evaluation of one item against the watchdog state
// depends on tpw_pkg
module tpw_eval (
   input  tpw_pkg::tpw_cfg_type    cfg,
   input  tpw_pkg::tpw_state_type  cur,
   input  logic                    command,
   input  logic [31:0]             now_ms,
   input  logic [2:0]              state_code,
   output tpw_pkg::tpw_state_type  nxt,
   output tpw_pkg::tpw_result_type res
);
   import tpw_pkg::*;

   logic [LIMIT_W-1:0]          limit_ms;
   logic                        watched;
   logic                        primed;
   logic [31:0]                 elapsed;
   logic                        trip;
   logic                        win_expired;
   logic [31:0]                 win_start_new;
   logic [7:0]                  recent_base;
   logic [7:0]                  recent_new;
   logic                        repeat_hit;
   logic                        burst_hit;
   logic [1:0]                  trip_tier;
   logic [32+MAGIC_W-1:0]       div_prod;
   logic [15:0]                 trips_new;
   logic [15:0]                 resets_new;

   always_comb begin
      case (state_code)
         ST_INIT, ST_ERROR, ST_SLEEPING: limit_ms = cfg.limit_short_ms;
         ST_CONNECTING, ST_REPORTING:    limit_ms = cfg.limit_link_ms;
         ST_UPDATE:                      limit_ms = cfg.limit_update_ms;
         default:                        limit_ms = '0;
      endcase
   end

   assign watched = (limit_ms != '0);
   assign primed  = (cur.progress_time != 32'd0);
   assign elapsed = now_ms - cur.progress_time;
   assign trip    = (command == CMD_CHECK) && watched && primed
                    && (now_ms >= cur.backoff_until)
                    && ({{(32-LIMIT_W){1'b0}}, limit_ms} <= elapsed);

   // burst window bookkeeping
   assign win_expired   = (cur.window_start == 32'd0)
                          || ((now_ms - cur.window_start) > cfg.burst_window_ms);
   assign win_start_new = win_expired ? now_ms : cur.window_start;
   assign recent_base   = win_expired ? 8'd0 : cur.recent_trips;
   assign recent_new    = (recent_base == 8'hFF) ? recent_base : recent_base + 8'd1;

   assign repeat_hit = (cur.previous_trip_time != 32'd0)
                       && ((now_ms - cur.previous_trip_time) <= cfg.repeat_window_ms);
   assign burst_hit  = ((now_ms - win_start_new) <= cfg.burst_window_ms)
                       && (recent_new >= cfg.burst_trip_limit);

   always_comb begin
      if (burst_hit) begin
         trip_tier = TIER_RESET;
      end else if (repeat_hit) begin
         trip_tier = TIER_DISCONNECT;
      end else begin
         trip_tier = TIER_BACKOFF;
      end
   end

   // seconds without progress by reciprocal multiply
   assign div_prod = {{MAGIC_W{1'b0}}, elapsed} * {32'd0, DIV_MAGIC};

   assign trips_new  = cur.trips_counted + 16'd1;
   assign resets_new = cur.resets_counted + 16'd1;

   always_comb begin
      nxt = cur;
      res.tier          = TIER_NONE;
      res.stall_seconds = '0;
      if (command == CMD_PROGRESS) begin
         nxt.progress_time = now_ms;
      end else if (watched && !primed) begin
         nxt.progress_time = now_ms;
      end else if (trip) begin
         nxt.trips_counted      = trips_new;
         nxt.window_start       = win_start_new;
         nxt.recent_trips       = recent_new;
         nxt.previous_trip_time = now_ms;
         nxt.backoff_until      = now_ms + cfg.backoff_len_ms;
         if (trip_tier == TIER_RESET) begin
            nxt.resets_counted = resets_new;
         end
         res.tier          = trip_tier;
         res.stall_seconds = div_prod[DIV_SHIFT+22:DIV_SHIFT];
      end
      res.alert       = res.tier[1];
      res.trip_total  = nxt.trips_counted;
      res.reset_total = nxt.resets_counted;
   end

endmodule

[rtl/tiered_progress_watchdog.sv]
// tiered_progress_watchdog: top level with input stage, state, result stage
// and configuration registers; depends on tpw_pkg and tpw_eval
//
// path: a request is registered in the input stage, evaluated by tpw_eval, and its
// result is registered in the result stage, from which it can transfer
// throughput: one item per cycle when rsp_stall is low; state_ff closes the eval loop
// reset: synchronous, active high; empties both stages, clears all watchdog
// state to zero and reloads the register defaults
module tiered_progress_watchdog (
   input  logic        clock,
   input  logic        reset,
   // request channel
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_command,
   input  logic [31:0] req_now_ms,
   input  logic [2:0]  req_state_code,
   // response channel
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic [1:0]  rsp_tier,
   output logic        rsp_alert,
   output logic [22:0] rsp_stall_seconds,
   output logic [15:0] rsp_trip_total,
   output logic [15:0] rsp_reset_total,
   // configuration writes
   input  logic        csr_we,
   input  logic [2:0]  csr_index,
   input  logic [31:0] csr_wdata
);
   import tpw_pkg::*;

   // input stage
   logic        in_valid_ff;
   logic        in_command_ff;
   logic [31:0] in_now_ff;
   logic [2:0]  in_code_ff;

   // result stage
   logic           out_valid_ff;
   tpw_result_type out_res_ff;

   tpw_cfg_type    cfg_ff,   cfg_in;
   tpw_state_type  state_ff;
   tpw_state_type  state_in;
   tpw_result_type res_in;

   logic                advance;
   logic                req_take;
   logic [LIMIT_W-1:0]  csr_limit_ms;

   // the input stage moves on when the result stage is empty or being drained
   assign advance   = in_valid_ff && (!out_valid_ff || !rsp_stall);
   assign req_stall = in_valid_ff && !advance;
   assign req_take  = req_valid && !req_stall;

   tpw_eval u_eval (
      .cfg        (cfg_ff),
      .cur        (state_ff),
      .command    (in_command_ff),
      .now_ms     (in_now_ff),
      .state_code (in_code_ff),
      .nxt        (state_in),
      .res        (res_in)
   );

   // input stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else if (req_take) begin
         in_valid_ff <= 1'b1;
      end else if (advance) begin
         in_valid_ff <= 1'b0;
      end
   end

   // input stage payload, no reset
   always_ff @(posedge clock) begin
      if (req_take) begin
         in_command_ff <= req_command;
         in_now_ff     <= req_now_ms;
         in_code_ff    <= req_state_code;
      end
   end

   // watchdog state updates once per evaluated item
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= '0;
      end else if (advance) begin
         state_ff <= state_in;
      end
   end

   // result stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (advance) begin
         out_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         out_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_res_ff <= res_in;
      end
   end

   // timeouts stored in milliseconds so the compare needs no multiply
   assign csr_limit_ms = LIMIT_W'({10'd0, csr_wdata[15:0]} * 26'(MS_PER_SEC));

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         case (csr_index)
            CSR_TIMEOUT_SHORT:  cfg_in.limit_short_ms   = csr_limit_ms;
            CSR_TIMEOUT_LINK:   cfg_in.limit_link_ms    = csr_limit_ms;
            CSR_TIMEOUT_UPDATE: cfg_in.limit_update_ms  = csr_limit_ms;
            CSR_BACKOFF:        cfg_in.backoff_len_ms   = csr_wdata;
            CSR_REPEAT_WINDOW:  cfg_in.repeat_window_ms = csr_wdata;
            CSR_BURST_WINDOW:   cfg_in.burst_window_ms  = csr_wdata;
            CSR_BURST_LIMIT:    cfg_in.burst_trip_limit = csr_wdata[7:0];
            default:            cfg_in = cfg_ff;    // unused index
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.limit_short_ms   <= LIMIT_W'(TIMEOUT_SHORT_RST * MS_PER_SEC);
         cfg_ff.limit_link_ms    <= LIMIT_W'(TIMEOUT_LINK_RST * MS_PER_SEC);
         cfg_ff.limit_update_ms  <= LIMIT_W'(TIMEOUT_UPDATE_RST * MS_PER_SEC);
         cfg_ff.backoff_len_ms   <= BACKOFF_RST;
         cfg_ff.repeat_window_ms <= REPEAT_WINDOW_RST;
         cfg_ff.burst_window_ms  <= BURST_WINDOW_RST;
         cfg_ff.burst_trip_limit <= BURST_LIMIT_RST;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign rsp_valid         = out_valid_ff;
   assign rsp_tier          = out_res_ff.tier;
   assign rsp_alert         = out_res_ff.alert;
   assign rsp_stall_seconds = out_res_ff.stall_seconds;
   assign rsp_trip_total    = out_res_ff.trip_total;
   assign rsp_reset_total   = out_res_ff.reset_total;

endmodule

[rtl/tpw_checker.sv]
// tpw_checker: port-level assertions for the tiered progress watchdog,
// bound to the top level; depends on tpw_pkg
module tpw_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_stall,
   input logic        rsp_valid,
   input logic        rsp_stall,
   input logic [1:0]  rsp_tier,
   input logic        rsp_alert,
   input logic [22:0] rsp_stall_seconds,
   input logic [15:0] rsp_trip_total,
   input logic [15:0] rsp_reset_total
);
   import tpw_pkg::*;

   // alert follows the tier
   a_alert_tier: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_alert == (rsp_tier == TIER_DISCONNECT || rsp_tier == TIER_RESET)))
      else $error("alert does not match tier");

   // no stall time reported without a trip
   a_no_trip_no_stall: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_tier == TIER_NONE) |-> (rsp_stall_seconds == 23'd0))
      else $error("stall seconds without a trip");

   // nothing comes out in the first cycle after reset
   a_empty_after_reset: assert property (@(posedge clock) disable iff (reset)
      $past(reset) |-> !rsp_valid)
      else $error("response valid right after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_stall) |=> (rsp_valid && $stable(rsp_tier)
         && $stable(rsp_stall_seconds) && $stable(rsp_trip_total)
         && $stable(rsp_reset_total)))
      else $error("stalled response changed");

   // requests are only held off behind a waiting response
   a_req_stall_cause: assert property (@(posedge clock) disable iff (reset)
      req_stall |-> (rsp_valid && rsp_stall))
      else $error("request stalled with no waiting response");

endmodule

bind tiered_progress_watchdog tpw_checker u_tpw_checker (.*);
